/* src/tfn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared widths, payload types and helpers of the triangle face normal core.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int CoordW = 16;               // vertex coordinate width
  localparam int FracB  = 14;               // fraction bits of the normal
  localparam int NormB  = 30;               // bit length after normalization
  localparam int EdgeW  = CoordW + 1;       // exact edge component
  localparam int ProdW  = 2 * EdgeW;        // edge product
  localparam int MagW   = ProdW;            // cross product magnitude
  localparam int BlW    = $clog2(MagW + 1);
  localparam int SqW    = 2 * NormB;
  localparam int SumW   = SqW + 2;
  localparam int RootW  = NormB + 1;
  localparam int TrialW = SumW + 2;
  localparam int NumW   = NormB + FracB + 2;
  localparam int QuoW   = FracB + 1;
  localparam int OutW   = 16;

  typedef struct packed {
    logic [2:0]            neg;
    logic                  degen;
    logic [BlW-1:0]        bl;
    logic [2:0][MagW-1:0]  mag;
  } tfn_cross_t;

  typedef struct packed {
    logic [2:0]            neg;
    logic                  degen;
    logic [SumW-1:0]       sum;
  } tfn_sq_t;

  typedef struct packed {
    logic [2:0]            neg;
    logic                  degen;
    logic [RootW-1:0]      root;
  } tfn_root_t;

  typedef struct packed {
    logic [2:0]            neg;
    logic                  degen;
    logic [RootW-1:0]      root;
    logic [2:0][NumW-1:0]  rem;
    logic [2:0][QuoW-1:0]  quo;
  } tfn_div_t;

  function automatic logic [BlW-1:0] bit_len(input logic [MagW-1:0] x);
    logic [BlW-1:0] n;
    n = '0;
    for (int i = 0; i < MagW; i++) begin
      if (x[i]) n = BlW'(i + 1);
    end
    return n;
  endfunction

endpackage

/* src/tfn_cross.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_cross
// Edges, cross product, magnitudes and common bit length (four stages).
// ----------------------------------------------------------------------------
module tfn_cross (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [tfn_pkg::CoordW-1:0]   in_p [9],
  output logic                                out_valid,
  input  logic                                out_ready,
  output tfn_pkg::tfn_cross_t                 out_data
);
  import tfn_pkg::*;

  logic [3:0] v_r;
  logic [3:0] en;
  logic signed [EdgeW-1:0] e0_r [3];
  logic signed [EdgeW-1:0] e1_r [3];
  logic signed [ProdW-1:0] p_r [6];
  logic [2:0][MagW-1:0]    mag_r;
  logic [2:0]              neg_r;
  tfn_cross_t              res_r;
  logic signed [ProdW:0]   c_nxt [3];

  assign en[3] = !v_r[3] || out_ready;
  assign en[2] = !v_r[2] || en[3];
  assign en[1] = !v_r[1] || en[2];
  assign en[0] = !v_r[0] || en[1];
  assign in_ready  = en[0];
  assign out_valid = v_r[3];
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
      if (en[3]) v_r[3] <= v_r[2];
    end
  end

  always_comb begin
    c_nxt[0] = (ProdW+1)'(p_r[0]) - (ProdW+1)'(p_r[1]);
    c_nxt[1] = (ProdW+1)'(p_r[2]) - (ProdW+1)'(p_r[3]);
    c_nxt[2] = (ProdW+1)'(p_r[4]) - (ProdW+1)'(p_r[5]);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        e0_r[i] <= EdgeW'(in_p[i])     - EdgeW'(in_p[3 + i]);
        e1_r[i] <= EdgeW'(in_p[6 + i]) - EdgeW'(in_p[3 + i]);
      end
    end
    if (en[1]) begin
      p_r[0] <= ProdW'(e0_r[1]) * ProdW'(e1_r[2]);
      p_r[1] <= ProdW'(e0_r[2]) * ProdW'(e1_r[1]);
      p_r[2] <= ProdW'(e0_r[2]) * ProdW'(e1_r[0]);
      p_r[3] <= ProdW'(e0_r[0]) * ProdW'(e1_r[2]);
      p_r[4] <= ProdW'(e0_r[0]) * ProdW'(e1_r[1]);
      p_r[5] <= ProdW'(e0_r[1]) * ProdW'(e1_r[0]);
    end
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        neg_r[i] <= c_nxt[i][ProdW];
        mag_r[i] <= c_nxt[i][ProdW] ? MagW'(-c_nxt[i]) : MagW'(c_nxt[i]);
      end
    end
    if (en[3]) begin
      // bit length of the or equals that of the largest magnitude
      res_r.bl    <= bit_len(mag_r[0] | mag_r[1] | mag_r[2]);
      res_r.degen <= (mag_r[0] | mag_r[1] | mag_r[2]) == '0;
      res_r.neg   <= neg_r;
      res_r.mag   <= mag_r;
    end
  end

endmodule

/* src/tfn_norm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_norm
// Common shift to a fixed bit length, squares and their sum (three stages).
// ----------------------------------------------------------------------------
module tfn_norm (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tfn_pkg::tfn_cross_t             in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tfn_pkg::tfn_sq_t                out_data,
  output logic [2:0][tfn_pkg::NormB-1:0]  out_d
);
  import tfn_pkg::*;

  logic [2:0] v_r;
  logic [2:0] en;
  logic [2:0][NormB-1:0] d1_r, d2_r, d3_r;
  logic [2:0]            neg1_r, neg2_r;
  logic                  dg1_r, dg2_r;
  logic [2:0][SqW-1:0]   sq_r;
  tfn_sq_t               res_r;
  logic [MagW-1:0]       sh [3];

  assign en[2] = !v_r[2] || out_ready;
  assign en[1] = !v_r[1] || en[2];
  assign en[0] = !v_r[0] || en[1];
  assign in_ready  = en[0];
  assign out_valid = v_r[2];
  assign out_data  = res_r;
  assign out_d     = d3_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (in_data.bl > BlW'(NormB))
        sh[i] = in_data.mag[i] >> (in_data.bl - BlW'(NormB));
      else
        sh[i] = in_data.mag[i] << (BlW'(NormB) - in_data.bl);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) d1_r[i] <= sh[i][NormB-1:0];
      neg1_r <= in_data.neg;
      dg1_r  <= in_data.degen;
    end
    if (en[1]) begin
      for (int i = 0; i < 3; i++) sq_r[i] <= SqW'(d1_r[i]) * SqW'(d1_r[i]);
      d2_r   <= d1_r;
      neg2_r <= neg1_r;
      dg2_r  <= dg1_r;
    end
    if (en[2]) begin
      res_r.sum   <= SumW'(sq_r[0]) + SumW'(sq_r[1]) + SumW'(sq_r[2]);
      res_r.neg   <= neg2_r;
      res_r.degen <= dg2_r;
      d3_r        <= d2_r;
    end
  end

endmodule

/* src/tfn_isqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_isqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module tfn_isqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tfn_pkg::tfn_sq_t                in_data,
  input  logic [2:0][tfn_pkg::NormB-1:0]  in_d,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tfn_pkg::tfn_root_t              out_data,
  output logic [2:0][tfn_pkg::NormB-1:0]  out_d
);
  import tfn_pkg::*;

  logic [RootW-1:0]              v_r;
  logic [RootW:0]                en;
  logic [SumW-1:0]               rem_r [RootW];
  tfn_root_t                     st_r  [RootW];
  logic [2:0][NormB-1:0]         d_r   [RootW];

  assign en[RootW] = out_ready;
  assign in_ready  = en[0];
  assign out_valid = v_r[RootW-1];
  assign out_data  = st_r[RootW-1];
  assign out_d     = d_r[RootW-1];

  for (genvar j = 0; j < RootW; j++) begin : g_stage
    localparam int K = RootW - 1 - j;
    logic [SumW-1:0]     rem_in;
    tfn_root_t           st_in;
    tfn_root_t           st_nxt;
    logic [2:0][NormB-1:0] d_in;
    logic                v_in;
    logic [TrialW-1:0]   trial;
    logic                take;

    assign en[j] = !v_r[j] || en[j+1];

    if (j == 0) begin : g_first
      assign rem_in = in_data.sum;
      assign st_in  = '{neg: in_data.neg, degen: in_data.degen, root: '0};
      assign d_in   = in_d;
      assign v_in   = in_valid;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign st_in  = st_r[j-1];
      assign d_in   = d_r[j-1];
      assign v_in   = v_r[j-1];
    end

    // adding bit k to root q grows its square by (2q + 2^k) * 2^k
    assign trial = ((TrialW'(st_in.root) << 1) + (TrialW'(1) << K)) << K;
    assign take  = TrialW'(rem_in) >= trial;

    always_comb begin
      st_nxt         = st_in;
      st_nxt.root[K] = take;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[j] <= 1'b0;
      else if (en[j]) v_r[j] <= v_in;
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        st_r[j]  <= st_nxt;
        d_r[j]   <= d_in;
        rem_r[j] <= take ? rem_in - trial[SumW-1:0] : rem_in;
      end
    end
  end

endmodule

/* src/tfn_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_div
// Rounded division of each component by the root, one quotient bit per
// stage, then sign and output formatting.
// ----------------------------------------------------------------------------
module tfn_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  tfn_pkg::tfn_root_t                in_data,
  input  logic [2:0][tfn_pkg::NormB-1:0]    in_d,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tfn_pkg::OutW-1:0]   out_nx,
  output logic signed [tfn_pkg::OutW-1:0]   out_ny,
  output logic signed [tfn_pkg::OutW-1:0]   out_nz,
  output logic                              out_degenerate
);
  import tfn_pkg::*;

  localparam int NSt = QuoW + 2;  // prep, one stage per quotient bit, output

  logic [NSt-1:0]    v_r;
  logic [NSt:0]      en;
  tfn_div_t          st_r [QuoW+1];
  logic [OutW-1:0]   n_r [3];
  logic              dg_r;
  logic [QuoW-1:0]   qc [3];
  tfn_div_t          prep;

  assign en[NSt]   = out_ready;
  assign in_ready  = en[0];
  assign out_valid = v_r[NSt-1];
  assign out_nx    = n_r[0];
  assign out_ny    = n_r[1];
  assign out_nz    = n_r[2];
  assign out_degenerate = dg_r;

  for (genvar j = 0; j < NSt; j++) begin : g_en
    assign en[j] = !v_r[j] || en[j+1];
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[j] <= 1'b0;
      else if (en[j]) v_r[j] <= (j == 0) ? in_valid : v_r[(j == 0) ? 0 : j-1];
    end
  end

  always_comb begin
    prep.neg   = in_data.neg;
    prep.degen = in_data.degen;
    prep.root  = in_data.root;
    prep.quo   = '0;
    for (int i = 0; i < 3; i++) begin
      prep.rem[i] = (NumW'(in_d[i]) << FracB) + NumW'(in_data.root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) st_r[0] <= prep;
  end

  for (genvar j = 1; j <= QuoW; j++) begin : g_stage
    localparam int K = QuoW - j;
    logic [NumW-1:0] trial;
    tfn_div_t        st_nxt;
    assign trial = NumW'(st_r[j-1].root) << K;

    always_comb begin
      st_nxt = st_r[j-1];
      for (int i = 0; i < 3; i++) begin
        if (st_r[j-1].rem[i] >= trial) begin
          st_nxt.rem[i]    = st_r[j-1].rem[i] - trial;
          st_nxt.quo[i][K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) st_r[j] <= st_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (st_r[QuoW].quo[i] > QuoW'(1 << FracB)) ? QuoW'(1 << FracB)
                                                      : st_r[QuoW].quo[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NSt-1]) begin
      dg_r <= st_r[QuoW].degen;
      for (int i = 0; i < 3; i++) begin
        if (st_r[QuoW].degen)
          n_r[i] <= '0;
        else if (st_r[QuoW].neg[i])
          n_r[i] <= OutW'(-OutW'(qc[i]));
        else
          n_r[i] <= OutW'(qc[i]);
      end
    end
  end

endmodule

/* src/triangle_face_normal_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_face_normal_core
// Unit face normal of a triangle, Q1.14 components, with degenerate flag.
// ----------------------------------------------------------------------------
// One triangle enters per cycle and one normal leaves per cycle while
// out_ready is high; each transaction passes through edges and cross
// product, normalization and sum of squares, the bit-per-stage square root
// and the bit-per-stage divide and output register. Every stage has its
// own valid bit and stalls only when full and the next stage cannot take
// its item, so result back pressure fills empty slots before input stops.
module triangle_face_normal_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [tfn_pkg::CoordW-1:0]  in_ax,
  input  logic signed [tfn_pkg::CoordW-1:0]  in_ay,
  input  logic signed [tfn_pkg::CoordW-1:0]  in_az,
  input  logic signed [tfn_pkg::CoordW-1:0]  in_bx,
  input  logic signed [tfn_pkg::CoordW-1:0]  in_by,
  input  logic signed [tfn_pkg::CoordW-1:0]  in_bz,
  input  logic signed [tfn_pkg::CoordW-1:0]  in_cx,
  input  logic signed [tfn_pkg::CoordW-1:0]  in_cy,
  input  logic signed [tfn_pkg::CoordW-1:0]  in_cz,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [tfn_pkg::OutW-1:0]    out_nx,
  output logic signed [tfn_pkg::OutW-1:0]    out_ny,
  output logic signed [tfn_pkg::OutW-1:0]    out_nz,
  output logic                               out_degenerate
);
  import tfn_pkg::*;

  logic signed [CoordW-1:0] p [9];
  logic cr_valid, cr_ready, nm_valid, nm_ready, sq_valid, sq_ready;
  tfn_cross_t cr_data;
  tfn_sq_t    sq_data;
  tfn_root_t  rt_data;
  logic [2:0][NormB-1:0] nm_d, rt_d;

  assign p[0] = in_ax;
  assign p[1] = in_ay;
  assign p[2] = in_az;
  assign p[3] = in_bx;
  assign p[4] = in_by;
  assign p[5] = in_bz;
  assign p[6] = in_cx;
  assign p[7] = in_cy;
  assign p[8] = in_cz;

  tfn_cross u_cross (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_p(p),
    .out_valid(cr_valid), .out_ready(cr_ready), .out_data(cr_data)
  );

  tfn_norm u_norm (
    .clk, .rst_n,
    .in_valid(cr_valid), .in_ready(cr_ready), .in_data(cr_data),
    .out_valid(nm_valid), .out_ready(nm_ready), .out_data(sq_data),
    .out_d(nm_d)
  );

  tfn_isqrt u_isqrt (
    .clk, .rst_n,
    .in_valid(nm_valid), .in_ready(nm_ready), .in_data(sq_data),
    .in_d(nm_d),
    .out_valid(sq_valid), .out_ready(sq_ready), .out_data(rt_data),
    .out_d(rt_d)
  );

  tfn_div u_div (
    .clk, .rst_n,
    .in_valid(sq_valid), .in_ready(sq_ready), .in_data(rt_data), .in_d(rt_d),
    .out_valid, .out_ready, .out_nx, .out_ny, .out_nz, .out_degenerate
  );

endmodule

/* src/tfn_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_checker
// Port-level checks of the triangle face normal core, bound to the top level.
// ----------------------------------------------------------------------------
module tfn_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [tfn_pkg::OutW-1:0]    out_nx,
  input  logic signed [tfn_pkg::OutW-1:0]    out_ny,
  input  logic signed [tfn_pkg::OutW-1:0]    out_nz,
  input  logic                               out_degenerate
);
  import tfn_pkg::*;

  localparam logic signed [OutW-1:0] One = OutW'(1 << FracB);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_nx == '0 && out_ny == '0 && out_nz == '0)
    else $error("degenerate transaction with nonzero normal");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |->
      out_nx <= One && out_nx >= -One && out_ny <= One && out_ny >= -One &&
      out_nz <= One && out_nz >= -One)
    else $error("normal component outside unit range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_nx) && $stable(out_ny)
      && $stable(out_nz) && $stable(out_degenerate))
    else $error("stalled result changed");

endmodule

bind triangle_face_normal_core tfn_checker u_tfn_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_nx, .out_ny, .out_nz, .out_degenerate
);
